FILE: hw/rtl/pcpc_pkg.sv
// shared types and constants for the point cloud part cull block
`default_nettype none
package pcpc_pkg;

   // words per stored part
   localparam int WORDS = 14;

   // half-plane accumulator width
   localparam int ACC_W = 100;

   // word slots inside one part
   localparam logic [3:0] W_KIND = 4'd0;
   localparam logic [3:0] W_REV  = 4'd1;
   localparam logic [3:0] W_AX   = 4'd2;
   localparam logic [3:0] W_AY   = 4'd3;
   localparam logic [3:0] W_BX   = 4'd4;
   localparam logic [3:0] W_BY   = 4'd5;
   localparam logic [3:0] W_LAST = 4'd13;

   // control register indexes
   localparam logic [1:0] CSR_DIST_X = 2'd0;
   localparam logic [1:0] CSR_DIST_Y = 2'd1;
   localparam logic [1:0] CSR_DIST_Z = 2'd2;
   localparam logic [1:0] CSR_COUNT  = 2'd3;

   // datapath step codes within one part
   localparam logic [3:0] STEP_SH_LAST = 4'd5;
   localparam logic [3:0] STEP_SH_END  = 4'd6;
   localparam logic [3:0] STEP_DIFF    = 4'd7;
   localparam logic [3:0] STEP_MUL_XL  = 4'd8;
   localparam logic [3:0] STEP_MUL_XH  = 4'd9;
   localparam logic [3:0] STEP_MUL_YL  = 4'd10;
   localparam logic [3:0] STEP_MUL_YH  = 4'd11;
   localparam logic [3:0] STEP_ACC_END = 4'd12;
   localparam logic [3:0] STEP_HIT     = 4'd13;

   // commands from controller to datapath
   typedef struct packed {
      logic       clr;
      logic       wr;
      logic       rd;
      logic [3:0] rd_word;
      logic       cap;
      logic [3:0] cap_word;
      logic       step_en;
      logic [3:0] step;
   } cmd_type;

   // coordinate word for bound k: xlo/t1x, xhi/t2x, ylo/t1y, yhi/t2y, zlo, zhi
   function automatic logic [3:0] coord_word(input logic [2:0] k);
      logic [3:0] r;
      unique case (k)
         3'd0:    r = 4'd2;
         3'd1:    r = 4'd4;
         3'd2:    r = 4'd3;
         3'd3:    r = 4'd5;
         3'd4:    r = 4'd6;
         default: r = 4'd7;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pcpc_ram.sv
// generic simple dual port ram with registered read
`default_nettype none
module pcpc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 112
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/pcpc_ctrl.sv
// controller: sequences word fetch and arithmetic steps for each part
`default_nettype none
module pcpc_ctrl #(
   parameter int PARTS = 8,
   parameter int PI_W  = 3
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic            mode,
   input  wire logic [3:0]      part_count,
   output logic                 busy,
   output logic                 rsp_valid,
   output pcpc_pkg::cmd_type    cmd,
   output logic [PI_W-1:0]      part_idx
);

   localparam int CNT_W = $clog2(PARTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_CALC  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] part_ff, part_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [3:0]       wc_ff, wc_in;
   logic [3:0]       step_ff, step_in;
   logic [CNT_W-1:0] n_eff;
   logic             accept;
   logic             more;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign part_idx = part_ff[PI_W-1:0];

   // clamp the part count to the table size
   always_comb begin
      if (32'(part_count) > PARTS) begin
         n_eff = CNT_W'(PARTS);
      end else begin
         n_eff = CNT_W'(part_count);
      end
   end

   assign more = ((CNT_W + 1)'(part_ff) + 1'b1) < (CNT_W + 1)'(n_ff);

   // next state and counters
   always_comb begin
      state_in = state_ff;
      part_in  = part_ff;
      n_in     = n_ff;
      wc_in    = wc_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && mode) begin
               n_in    = n_eff;
               part_in = '0;
               wc_in   = '0;
               if (n_eff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            if (wc_ff == pcpc_pkg::W_LAST + 4'd1) begin
               step_in  = '0;
               state_in = ST_CALC;
            end else begin
               wc_in = wc_ff + 4'd1;
            end
         end
         ST_CALC: begin
            if (step_ff == pcpc_pkg::STEP_HIT) begin
               wc_in = '0;
               if (more) begin
                  part_in  = part_ff + 1'b1;
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands to the datapath
   always_comb begin
      cmd          = '0;
      cmd.clr      = accept && mode;
      cmd.wr       = accept && !mode;
      cmd.rd       = (state_ff == ST_FETCH) && (wc_ff <= pcpc_pkg::W_LAST);
      cmd.rd_word  = wc_ff;
      cmd.cap      = (state_ff == ST_FETCH) && (wc_ff != 4'd0);
      cmd.cap_word = wc_ff - 4'd1;
      cmd.step_en  = (state_ff == ST_CALC);
      cmd.step     = step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         part_ff  <= '0;
         n_ff     <= '0;
         wc_ff    <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         part_ff  <= part_in;
         n_ff     <= n_in;
         wc_ff    <= wc_in;
         step_ff  <= step_in;
      end
   end

   // a captured word always follows a read issued the cycle before
   a_cap_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.cap |-> $past(cmd.rd))
      else $error("word captured without a preceding read");

   // the result strobe lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // a point transfer makes the block busy
   a_point_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && mode) |=> busy)
      else $error("point accepted but block not busy");

   // a load transfer leaves the block idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !mode) |=> !busy)
      else $error("load transfer left the block busy");

endmodule
`default_nettype wire

FILE: hw/rtl/pcpc_dpath.sv
// datapath: part storage, bound shifts, half-plane sum and hit flag
`default_nettype none
module pcpc_dpath #(
   parameter int PARTS = 8,
   parameter int PI_W  = 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire pcpc_pkg::cmd_type  cmd,
   input  wire logic [PI_W-1:0]    part_idx,
   input  wire logic [2:0]         part_slot,
   input  wire logic [3:0]         word_slot,
   input  wire logic signed [31:0] load_value,
   input  wire logic signed [31:0] point_x,
   input  wire logic signed [31:0] point_y,
   input  wire logic signed [31:0] point_z,
   input  wire logic [30:0]        dist_x,
   input  wire logic [30:0]        dist_y,
   input  wire logic [30:0]        dist_z,
   output logic                    flag
);

   localparam int DEPTH  = PARTS * pcpc_pkg::WORDS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int ACC_W  = pcpc_pkg::ACC_W;

   logic [31:0]              w_ff [pcpc_pkg::WORDS];
   logic signed [31:0]       px_ff, py_ff, pz_ff;
   logic signed [63:0]       sh_ff [6];
   logic signed [65:0]       mul_ff;
   logic signed [64:0]       dx_ff, dy_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic                     flag_ff;
   logic [31:0]              rd_data;
   logic                     wr_ok;
   logic [ADDR_W-1:0]        wr_addr, rd_addr;
   logic signed [63:0]       px, py, pz;
   logic signed [32:0]       nx, ny, mul_a, mul_b;
   logic [30:0]              dist_k;
   logic [2:0]               k;
   logic signed [63:0]       coord_k;
   logic signed [63:0]       xlo, xhi, ylo, yhi;
   logic                     hit_box, hit_tri, hit;

   // part table
   assign wr_ok = cmd.wr && (32'(part_slot) < PARTS) && (word_slot <= pcpc_pkg::W_LAST);
   assign wr_addr = ADDR_W'(32'(part_slot) * pcpc_pkg::WORDS + 32'(word_slot));
   assign rd_addr = ADDR_W'(32'(part_idx) * pcpc_pkg::WORDS + 32'(cmd.rd_word));

   pcpc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (load_value),
      .rd_en   (cmd.rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // point widened to q32.32
   assign px = {{16{px_ff[31]}}, px_ff, 16'd0};
   assign py = {{16{py_ff[31]}}, py_ff, 16'd0};
   assign pz = {{16{pz_ff[31]}}, pz_ff, 16'd0};

   // edge normal, negated for a reversed part
   always_comb begin
      nx = 33'(signed'(w_ff[pcpc_pkg::W_BY])) - 33'(signed'(w_ff[pcpc_pkg::W_AY]));
      ny = 33'(signed'(w_ff[pcpc_pkg::W_AX])) - 33'(signed'(w_ff[pcpc_pkg::W_BX]));
      if (w_ff[pcpc_pkg::W_REV] != 32'd0) begin
         nx = -nx;
         ny = -ny;
      end
   end

   // bound index for the sum steps, one behind the product
   assign k = cmd.step[2:0] - 3'd1;

   // margin for the product formed in this step
   always_comb begin
      unique case (cmd.step[2:1])
         2'd0:    dist_k = dist_x;
         2'd1:    dist_k = dist_y;
         default: dist_k = dist_z;
      endcase
   end

   assign coord_k = {{16{w_ff[pcpc_pkg::coord_word(k)][31]}},
                     w_ff[pcpc_pkg::coord_word(k)], 16'd0};

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.step <= pcpc_pkg::STEP_SH_LAST) begin
         mul_a = 33'(signed'(w_ff[4'd8 + cmd.step]));
         mul_b = {2'b00, dist_k};
      end else if (cmd.step == pcpc_pkg::STEP_MUL_XL) begin
         mul_a = {1'b0, dx_ff[31:0]};
         mul_b = nx;
      end else if (cmd.step == pcpc_pkg::STEP_MUL_XH) begin
         mul_a = dx_ff[64:32];
         mul_b = nx;
      end else if (cmd.step == pcpc_pkg::STEP_MUL_YL) begin
         mul_a = {1'b0, dy_ff[31:0]};
         mul_b = ny;
      end else if (cmd.step == pcpc_pkg::STEP_MUL_YH) begin
         mul_a = dy_ff[64:32];
         mul_b = ny;
      end
   end

   // box and half-plane tests
   always_comb begin
      xlo = (sh_ff[0] < sh_ff[1]) ? sh_ff[0] : sh_ff[1];
      xhi = (sh_ff[0] < sh_ff[1]) ? sh_ff[1] : sh_ff[0];
      ylo = (sh_ff[2] < sh_ff[3]) ? sh_ff[2] : sh_ff[3];
      yhi = (sh_ff[2] < sh_ff[3]) ? sh_ff[3] : sh_ff[2];
      hit_box = (sh_ff[0] <= px) && (px <= sh_ff[1]) && (sh_ff[2] <= py) &&
                (py <= sh_ff[3]) && (sh_ff[4] <= pz) && (pz <= sh_ff[5]);
      hit_tri = acc_ff[ACC_W-1] && (xlo < px) && (px < xhi) && (ylo < py) &&
                (py < yhi) && (sh_ff[4] < pz) && (pz < sh_ff[5]);
      hit = (w_ff[pcpc_pkg::W_KIND] == 32'd0) ? hit_box : hit_tri;
   end

   // word capture, point latch and arithmetic steps
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         px_ff <= point_x;
         py_ff <= point_y;
         pz_ff <= point_z;
      end
      if (cmd.cap) begin
         w_ff[cmd.cap_word] <= rd_data;
      end
      if (cmd.step_en) begin
         mul_ff <= mul_a * mul_b;
         if (cmd.step != 4'd0 && cmd.step <= pcpc_pkg::STEP_SH_END) begin
            sh_ff[k] <= coord_k + mul_ff[63:0];
         end
         if (cmd.step == pcpc_pkg::STEP_DIFF) begin
            dx_ff <= 65'(px) - 65'(sh_ff[0]);
            dy_ff <= 65'(py) - 65'(sh_ff[2]);
         end
         if (cmd.step == pcpc_pkg::STEP_MUL_XH) begin
            acc_ff <= ACC_W'(mul_ff);
         end else if (cmd.step == pcpc_pkg::STEP_MUL_YL ||
                      cmd.step == pcpc_pkg::STEP_ACC_END) begin
            acc_ff <= acc_ff + (ACC_W'(mul_ff) <<< 32);
         end else if (cmd.step == pcpc_pkg::STEP_MUL_YH) begin
            acc_ff <= acc_ff + ACC_W'(mul_ff);
         end
      end
   end

   // running hit flag over the tested parts
   always_ff @(posedge clock) begin
      if (reset || cmd.clr) begin
         flag_ff <= 1'b0;
      end else if (cmd.step_en && cmd.step == pcpc_pkg::STEP_HIT && hit) begin
         flag_ff <= 1'b1;
      end
   end

   assign flag = flag_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/point_cloud_part_cull.sv
// top level of the point cloud part cull block
`default_nettype none
// Crops a point cloud against up to PARTS stored machine parts (cuboids or
// tri-pillars). Items enter on the req_ ports: an item transfers at a rising
// edge with start high and busy low. A load item (req_mode 0) writes one word
// of one part into the part table in that cycle and gives no result; the
// block stays idle and takes the next item in the following cycle. A point
// item (req_mode 1) gives one result: rsp_remove_flag, shown with rsp_valid
// for exactly one cycle, which the receiver must take then.
// A point item tests each part in turn: it reads the part's 14 words through
// the single table read port, then runs its steps through the shared 33x33
// multiplier. The strobe comes after the last tested part, n being part_count
// clamped to PARTS (no part is tested if n is 0); the next item is taken the cycle
// after the strobe. csr_ writes set the margins and the part count; the user
// must make them while the block is idle, which the block does not enforce.
// Reset clears the controller, csr_ registers and hit flag; the part table
// keeps no reset value and parts must be loaded before they are tested.
module point_cloud_part_cull #(
   parameter int PARTS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_mode,
   input  wire logic [2:0]         req_part_slot,
   input  wire logic [3:0]         req_word_slot,
   input  wire logic signed [31:0] req_load_value,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_point_z,
   output logic                    rsp_valid,
   output logic                    rsp_remove_flag,
   input  wire logic               csr_we,
   input  wire logic [1:0]         csr_index,
   input  wire logic [30:0]        csr_wdata
);

   localparam int PI_W = (PARTS > 1) ? $clog2(PARTS) : 1;

   logic [30:0]       dist_x_ff, dist_y_ff, dist_z_ff;
   logic [3:0]        count_ff;
   pcpc_pkg::cmd_type cmd;
   logic [PI_W-1:0]   part_idx;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_x_ff <= '0;
         dist_y_ff <= '0;
         dist_z_ff <= '0;
         count_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            pcpc_pkg::CSR_DIST_X: dist_x_ff <= csr_wdata;
            pcpc_pkg::CSR_DIST_Y: dist_y_ff <= csr_wdata;
            pcpc_pkg::CSR_DIST_Z: dist_z_ff <= csr_wdata;
            pcpc_pkg::CSR_COUNT:  count_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   pcpc_ctrl #(.PARTS(PARTS), .PI_W(PI_W)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .mode       (req_mode),
      .part_count (count_ff),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd),
      .part_idx   (part_idx)
   );

   pcpc_dpath #(.PARTS(PARTS), .PI_W(PI_W)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .part_idx   (part_idx),
      .part_slot  (req_part_slot),
      .word_slot  (req_word_slot),
      .load_value (req_load_value),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .point_z    (req_point_z),
      .dist_x     (dist_x_ff),
      .dist_y     (dist_y_ff),
      .dist_z     (dist_z_ff),
      .flag       (rsp_remove_flag)
   );

endmodule
`default_nettype wire
